// ----- src/cfc_pkg.sv -----
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared types, constants and the CRC-64/XZ byte update for the chunk
// frame checker.
// ----------------------------------------------------------------------------
package cfc_pkg;

  // Frame layout
  localparam int unsigned HDR_LEN = 36;
  localparam int unsigned TRAILER_BYTES = 8;
  localparam int unsigned TOTAL_W = 34;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // CRC-64/XZ: reflected ECMA-182 polynomial, init and final xor all ones
  localparam logic [63:0] CRC_POLY = 64'hC96C5795D7870F42;
  localparam logic [63:0] CRC_ONES = 64'hFFFFFFFFFFFFFFFF;

  // Magic bytes, entry 0 arrives first
  localparam logic [3:0][7:0] MAGIC = {8'h42, 8'h44, 8'h53, 8'h54};

  // Format version after reset
  localparam logic [31:0] VERSION_RESET = 32'd2;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_MAGIC   = 3'd2,
    ST_VERSION = 3'd3,
    ST_SIZE    = 3'd4,
    ST_CRC     = 3'd5
  } status_e;

  typedef struct packed {
    status_e            status;
    logic [31:0]        num_points;
    logic signed [63:0] first_time;
    logic signed [63:0] last_time;
    logic [31:0]        time_stream_len;
    logic [31:0]        value_stream_len;
  } result_t;

  // Fold one byte into a reflected CRC-64 register
  function automatic logic [63:0] crc64_byte(input logic [63:0] crc, input logic [7:0] b);
    logic [63:0] c;
    c = crc ^ {56'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- src/cfc_frame_core.sv -----
// ----------------------------------------------------------------------------
// cfc_frame_core
// Per-frame state: header capture, byte count, trailer delay line and
// running CRC. Evaluates the frame status on the last byte.
// ----------------------------------------------------------------------------
module cfc_frame_core
  import cfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic        last_i,
  input  logic [31:0] version_i,
  output result_t     res_o
);

  logic [63:0]        crc_q, crc_d;
  logic [7:0][7:0]    held_q, held_d;
  logic [TOTAL_W-1:0] tot_q, tot_d;
  logic               magic_q, magic_d;
  logic [31:0]        ver_q, ver_d;
  logic [31:0]        cnt_q, cnt_d;
  logic [63:0]        ftime_q, ftime_d;
  logic [63:0]        ltime_q, ltime_d;
  logic [31:0]        tlen_q, tlen_d;
  logic [31:0]        vlen_q, vlen_d;

  logic [5:0]         idx;
  logic [5:0]         fdiff, ldiff;
  logic [2:0]         fpos, lpos;
  logic               in_hdr;
  logic [TOTAL_W-1:0] expected;
  status_e            status;

  assign idx    = tot_q[5:0];
  assign in_hdr = tot_q < TOTAL_W'(HDR_LEN);
  assign fdiff  = idx - 6'd12;
  assign ldiff  = idx - 6'd20;
  assign fpos   = fdiff[2:0];
  assign lpos   = ldiff[2:0];

  // Capture header bytes at their little-endian positions
  always_comb begin
    magic_d = magic_q;
    ver_d   = ver_q;
    cnt_d   = cnt_q;
    ftime_d = ftime_q;
    ltime_d = ltime_q;
    tlen_d  = tlen_q;
    vlen_d  = vlen_q;
    if (in_hdr) begin
      unique case (idx) inside
        [6'd0:6'd3]: begin
          if (byte_i != MAGIC[idx[1:0]]) magic_d = 1'b0;
        end
        [6'd4:6'd7]:   ver_d[8*idx[1:0] +: 8]  = byte_i;
        [6'd8:6'd11]:  cnt_d[8*idx[1:0] +: 8]  = byte_i;
        [6'd12:6'd19]: ftime_d[8*fpos +: 8]    = byte_i;
        [6'd20:6'd27]: ltime_d[8*lpos +: 8]    = byte_i;
        [6'd28:6'd31]: tlen_d[8*idx[1:0] +: 8] = byte_i;
        [6'd32:6'd35]: vlen_d[8*idx[1:0] +: 8] = byte_i;
        default: ;
      endcase
    end
  end

  // Shift the trailer line, fold the byte leaving it, count with saturation
  assign held_d = {byte_i, held_q[7:1]};
  assign crc_d  = (tot_q >= TOTAL_W'(TRAILER_BYTES)) ? crc64_byte(crc_q, held_q[0]) : crc_q;
  assign tot_d  = (tot_q != TOTAL_MAX) ? tot_q + TOTAL_W'(1) : tot_q;

  assign expected = TOTAL_W'(HDR_LEN + TRAILER_BYTES)
                  + {2'b00, tlen_d} + {2'b00, vlen_d};

  // Checks in priority order
  always_comb begin
    if (tot_d < TOTAL_W'(HDR_LEN + TRAILER_BYTES)) status = ST_SHORT;
    else if (!magic_d)                             status = ST_MAGIC;
    else if (ver_d != version_i)                   status = ST_VERSION;
    else if (expected != tot_d)                    status = ST_SIZE;
    else if ((crc_d ^ CRC_ONES) != held_d)         status = ST_CRC;
    else                                           status = ST_OK;
  end

  assign res_o.status           = status;
  assign res_o.num_points       = cnt_d;
  assign res_o.first_time       = signed'(ftime_d);
  assign res_o.last_time        = signed'(ltime_d);
  assign res_o.time_stream_len  = tlen_d;
  assign res_o.value_stream_len = vlen_d;

  // Advance the frame state, start over after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= CRC_ONES;
      held_q  <= '0;
      tot_q   <= '0;
      magic_q <= 1'b1;
      ver_q   <= '0;
      cnt_q   <= '0;
      ftime_q <= '0;
      ltime_q <= '0;
      tlen_q  <= '0;
      vlen_q  <= '0;
    end else if (step_i) begin
      if (last_i) begin
        crc_q   <= CRC_ONES;
        held_q  <= '0;
        tot_q   <= '0;
        magic_q <= 1'b1;
        ver_q   <= '0;
        cnt_q   <= '0;
        ftime_q <= '0;
        ltime_q <= '0;
        tlen_q  <= '0;
        vlen_q  <= '0;
      end else begin
        crc_q   <= crc_d;
        held_q  <= held_d;
        tot_q   <= tot_d;
        magic_q <= magic_d;
        ver_q   <= ver_d;
        cnt_q   <= cnt_d;
        ftime_q <= ftime_d;
        ltime_q <= ltime_d;
        tlen_q  <= tlen_d;
        vlen_q  <= vlen_d;
      end
    end
  end

endmodule

// ----- src/cfc_out_reg.sv -----
// ----------------------------------------------------------------------------
// cfc_out_reg
// Result register: holds one finished result until the sink takes it.
// ----------------------------------------------------------------------------
module cfc_out_reg
  import cfc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  input  logic    out_stall_i,
  output logic    out_valid_o,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // Set on load, drop once taken
  always_comb begin
    valid_d = valid_q;
    if (load_i)            valid_d = 1'b1;
    else if (!out_stall_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the payload until the next load
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ----- src/chunk_frame_checker_top.sv -----
// ----------------------------------------------------------------------------
// chunk_frame_checker_top
// Streaming checker for framed chunk files, one byte per item.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle with no gaps of its own: a byte
// goes into an input register, and when that register advances the frame
// logic folds it into the header capture, byte count, eight-byte trailer
// line and the byte-wide CRC-64/XZ update. A byte flagged as last yields
// one result, loaded into the result register as the byte leaves the input
// register; every other byte yields none. The input stalls only when a last
// byte meets a result that the sink has not yet taken. The accepted version
// register may be written at any time the block is idle and resets to 2.
// ----------------------------------------------------------------------------
module chunk_frame_checker_top
  import cfc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [31:0]        num_points_o,
  output logic signed [63:0] first_time_o,
  output logic signed [63:0] last_time_o,
  output logic [31:0]        time_stream_len_o,
  output logic [31:0]        value_stream_len_o
);

  logic [31:0] version_q;
  logic        s1_valid_q, s1_valid_d;
  logic [7:0]  s1_byte_q;
  logic        s1_last_q;
  logic        accept;
  logic        blocked;
  logic        s1_fire;
  logic        load;
  result_t     core_res;
  result_t     out_res;

  // Version register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= VERSION_RESET;
    end else if (cfg_we_i) begin
      version_q <= cfg_wdata_i;
    end
  end

  // A last byte waits while the result register holds a result the sink has not taken
  assign blocked    = s1_valid_q && s1_last_q && out_valid_o && out_stall_i;
  assign in_stall_o = blocked;
  assign accept     = in_valid_i && !in_stall_o;
  assign s1_fire    = s1_valid_q && !blocked;
  assign load       = s1_fire && s1_last_q;

  // Input register
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept)       s1_valid_d = 1'b1;
    else if (s1_fire) s1_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  cfc_frame_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (s1_fire),
    .byte_i    (s1_byte_q),
    .last_i    (s1_last_q),
    .version_i (version_q),
    .res_o     (core_res)
  );

  cfc_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .res_i       (core_res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign status_o           = out_res.status;
  assign num_points_o       = out_res.num_points;
  assign first_time_o       = out_res.first_time;
  assign last_time_o        = out_res.last_time;
  assign time_stream_len_o  = out_res.time_stream_len;
  assign value_stream_len_o = out_res.value_stream_len;

  // Stall only for a last byte facing a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_last_q && out_valid_o))
    else $error("input stalled without a pending last byte");

  // Never overwrite a result the sink has not taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> !(out_valid_o && out_stall_i))
    else $error("result register overwritten while held");

  // A finished last byte shows a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o)
    else $error("last byte did not produce a result");

endmodule
